### rtl/cpt_pkg.sv
// constants, sine table and angle folding shared by the clarke/park datapath
// no dependencies
`default_nettype none

package cpt_pkg;

  localparam int CURRENT_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH = 9;
  localparam int UNIT_SHIFT = 10;
  localparam int SQRT3_Q10 = 1773;
  localparam int DIVISOR_W = 11;
  localparam int SINE_IDX_W = 7;
  localparam int SINE_MAG_W = 11;
  localparam int SINE_W = SINE_MAG_W + 1;

  typedef logic [ANGLE_WIDTH:0] deg_ext_t;

  localparam deg_ext_t QUARTER_TURN = deg_ext_t'(90);
  localparam deg_ext_t HALF_TURN = deg_ext_t'(180);
  localparam deg_ext_t THREE_QUARTER_TURN = deg_ext_t'(270);
  localparam deg_ext_t FULL_TURN = deg_ext_t'(360);

  typedef struct packed {
    logic                  neg;
    logic [SINE_IDX_W-1:0] idx;
  } fold_t;

  typedef logic signed [SINE_W-1:0] sine_t;

  localparam logic [SINE_MAG_W-1:0] QSINE [0:90] = '{
    11'd0,    11'd18,   11'd36,   11'd54,   11'd71,   11'd89,   11'd107,  11'd125,
    11'd143,  11'd160,  11'd178,  11'd195,  11'd213,  11'd230,  11'd248,  11'd265,
    11'd282,  11'd299,  11'd316,  11'd333,  11'd350,  11'd367,  11'd384,  11'd400,
    11'd416,  11'd433,  11'd449,  11'd465,  11'd481,  11'd496,  11'd512,  11'd527,
    11'd543,  11'd558,  11'd573,  11'd587,  11'd602,  11'd616,  11'd630,  11'd644,
    11'd658,  11'd672,  11'd685,  11'd698,  11'd711,  11'd724,  11'd737,  11'd749,
    11'd761,  11'd773,  11'd784,  11'd796,  11'd807,  11'd818,  11'd828,  11'd839,
    11'd849,  11'd859,  11'd868,  11'd878,  11'd887,  11'd896,  11'd904,  11'd912,
    11'd920,  11'd928,  11'd935,  11'd943,  11'd949,  11'd956,  11'd962,  11'd968,
    11'd974,  11'd979,  11'd984,  11'd989,  11'd994,  11'd998,  11'd1002, 11'd1005,
    11'd1008, 11'd1011, 11'd1014, 11'd1016, 11'd1018, 11'd1020, 11'd1022, 11'd1023,
    11'd1023, 11'd1024, 11'd1024
  };

  // one turn subtracted at most, then folded onto the quarter wave
  function automatic fold_t fold_angle(input deg_ext_t deg);
    deg_ext_t w;
    deg_ext_t i;
    fold_t    f;
    w = (deg >= FULL_TURN) ? deg - FULL_TURN : deg;
    if (w < QUARTER_TURN) begin
      i = w;
    end else if (w < HALF_TURN) begin
      i = HALF_TURN - w;
    end else if (w < THREE_QUARTER_TURN) begin
      i = w - HALF_TURN;
    end else begin
      i = FULL_TURN - w;
    end
    f.neg = (w >= HALF_TURN);
    f.idx = i[SINE_IDX_W-1:0];
    return f;
  endfunction

  function automatic sine_t sine_value(input fold_t f);
    sine_t m;
    m = sine_t'({1'b0, QSINE[f.idx]});
    return f.neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

### rtl/cpt_beta_div.sv
// pipelined (b - c) * 1024 / 1773 with truncation toward zero, four stages
// depends on cpt_pkg
`default_nettype none

module cpt_beta_div #(
  parameter int W = cpt_pkg::CURRENT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic signed [W:0] diff,
  output logic signed [W:0] beta
);
  import cpt_pkg::*;

  localparam int S = W + 2;
  localparam int NW = W + 1 + UNIT_SHIFT;
  // reciprocal rounded down: estimate is the quotient or one below it
  localparam logic [W+1:0] RECIP =
    (W+2)'((64'd1 << (W + 2 + UNIT_SHIFT)) / 64'(SQRT3_Q10));
  localparam logic [DIVISOR_W-1:0] DIVISOR = DIVISOR_W'(SQRT3_Q10);

  logic [W:0]      mag1;
  logic            neg1;
  logic [2*W+2:0]  mulq;
  logic [W-1:0]    qe2;
  logic [W:0]      mag2;
  logic            neg2;
  logic [NW-1:0]   prod3;
  logic [NW-1:0]   num3;
  logic [W-1:0]    qe3;
  logic            neg3;
  logic [NW-1:0]   rem;
  logic [W-1:0]    qc;

  assign mulq = (2*W+3)'(mag1) * (2*W+3)'(RECIP);
  assign rem  = num3 - prod3;
  assign qc   = qe3 + W'(rem >= NW'(DIVISOR));

  always_ff @(posedge clk) begin
    neg1  <= diff[W];
    mag1  <= diff[W] ? -$unsigned(diff) : $unsigned(diff);
    qe2   <= mulq[S +: W];
    mag2  <= mag1;
    neg2  <= neg1;
    prod3 <= NW'(qe2) * NW'(DIVISOR);
    num3  <= {mag2, {UNIT_SHIFT{1'b0}}};
    qe3   <= qe2;
    neg3  <= neg2;
    beta  <= neg3 ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

endmodule

`default_nettype wire

### rtl/clarke_park_transform.sv
// clarke and park transform: three phase currents and an angle in, alpha/beta/q/d out
// depends on cpt_pkg and cpt_beta_div
//
//  channel   signals                                   direction
//  request   start, busy, phase_a/b/c, angle_deg       in (busy out)
//  result    strobe, alpha_out, beta_out, q_out, d_out out
//
// one request per cycle; each result appears after its request has passed through
// the six-stage datapath (divide, table read, rotation multiply, sum)
// busy follows rst, so requests are taken every cycle outside reset
// reset clears only the valid bits; no state is kept between requests
`default_nettype none

module clarke_park_transform #(
  parameter int CURRENT_WIDTH = cpt_pkg::CURRENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [CURRENT_WIDTH-1:0] phase_a,
  input  logic signed [CURRENT_WIDTH-1:0] phase_b,
  input  logic signed [CURRENT_WIDTH-1:0] phase_c,
  input  logic [cpt_pkg::ANGLE_WIDTH-1:0] angle_deg,
  output logic strobe,
  output logic signed [CURRENT_WIDTH-1:0] alpha_out,
  output logic signed [CURRENT_WIDTH:0]   beta_out,
  output logic signed [CURRENT_WIDTH+1:0] q_out,
  output logic signed [CURRENT_WIDTH+1:0] d_out
);
  import cpt_pkg::*;

  localparam int W = CURRENT_WIDTH;
  localparam int PW = W + SINE_W + 1;
  localparam int SW = PW + 1;
  localparam int STAGES = 6;

  logic              take;
  logic [STAGES-1:0] vld;
  logic signed [W:0] diff;
  logic signed [W:0] beta4;

  logic signed [W-1:0] a1, a2, a3, a4, alpha5;
  fold_t               sf1, cf1;
  sine_t               s2, c2, s3, c3, s4, c4;
  logic signed [PW-1:0] p_sa, p_ca, p_sb, p_cb;
  logic signed [W:0]    beta5;
  logic signed [SW-1:0] q_full, d_full;

  assign busy = rst;
  assign take = start && !busy;
  assign strobe = vld[STAGES-1];

  assign diff = $signed({phase_b[W-1], phase_b}) - $signed({phase_c[W-1], phase_c});

  cpt_beta_div #(.W(W)) u_div (
    .clk  (clk),
    .diff (diff),
    .beta (beta4)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], take};
    end
  end

  assign q_full = SW'(p_cb) - SW'(p_sa);
  assign d_full = SW'(p_ca) + SW'(p_sb);

  always_ff @(posedge clk) begin
    a1  <= phase_a;
    sf1 <= fold_angle(deg_ext_t'(angle_deg));
    cf1 <= fold_angle(deg_ext_t'(angle_deg) + QUARTER_TURN);
    a2  <= a1;
    s2  <= sine_value(sf1);
    c2  <= sine_value(cf1);
    a3  <= a2;
    s3  <= s2;
    c3  <= c2;
    a4  <= a3;
    s4  <= s3;
    c4  <= c3;
    p_sa   <= PW'(s4) * PW'(a4);
    p_ca   <= PW'(c4) * PW'(a4);
    p_sb   <= PW'(s4) * PW'(beta4);
    p_cb   <= PW'(c4) * PW'(beta4);
    alpha5 <= a4;
    beta5  <= beta4;
    // q and d: arithmetic shift right by the table scale, kept to the output width
    alpha_out <= alpha5;
    beta_out  <= beta5;
    q_out     <= q_full[UNIT_SHIFT +: W+2];
    d_out     <= d_full[UNIT_SHIFT +: W+2];
  end

endmodule

`default_nettype wire

### rtl/cpt_checker.sv
// port-level checks for clarke_park_transform, attached by bind
// depends on cpt_pkg
`default_nettype none

module cpt_checker #(
  parameter int W = cpt_pkg::CURRENT_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic signed [W-1:0] phase_a,
  input logic [cpt_pkg::ANGLE_WIDTH-1:0] angle_deg,
  input logic strobe,
  input logic signed [W-1:0] alpha_out,
  input logic signed [W:0]   beta_out,
  input logic signed [W+1:0] q_out,
  input logic signed [W+1:0] d_out
);
  import cpt_pkg::*;

  localparam int LAT = 6;

  // every request gives a result once it has passed through the pipeline
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT strobe)
    else $error("request without result");

  // no result without a request
  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (alpha_out == $past(phase_a, LAT)))
    else $error("alpha does not follow phase a");

  // at zero angle the rotation is the identity
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (strobe && ($past(angle_deg, LAT) == '0)) |->
      ((d_out == (W+2)'(alpha_out)) && (q_out == (W+2)'(beta_out))))
    else $error("zero angle rotation mismatch");

endmodule

bind clarke_park_transform cpt_checker #(.W(CURRENT_WIDTH)) u_cpt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .phase_a   (phase_a),
  .angle_deg (angle_deg),
  .strobe    (strobe),
  .alpha_out (alpha_out),
  .beta_out  (beta_out),
  .q_out     (q_out),
  .d_out     (d_out)
);

`default_nettype wire
